### hdl/mahp_pkg.sv
`timescale 1ns / 1ps

package mahp_pkg;

   // header field codes
   localparam logic [7:0] SYNC_BYTE     = 8'hff;
   localparam logic [3:0] SYNC_NIBBLE   = 4'hf;
   localparam logic [1:0] LAYER_CODE_RSVD = 2'd0;
   localparam logic [3:0] BITRATE_FREE  = 4'h0;
   localparam logic [3:0] BITRATE_BAD   = 4'hf;
   localparam logic [1:0] SRATE_RSVD    = 2'd3;
   localparam logic [1:0] CHMODE_SINGLE = 2'd3;

   // layer index: 0 layer I, 1 layer II, 2 layer III
   localparam logic [1:0] LAYER_I   = 2'd0;
   localparam logic [1:0] LAYER_II  = 2'd1;
   localparam logic [1:0] LAYER_III = 2'd2;

   // sample-rate index
   localparam logic [1:0] SIDX_44K = 2'd0;
   localparam logic [1:0] SIDX_48K = 2'd1;
   localparam logic [1:0] SIDX_32K = 2'd2;

   // IEC 61937 burst data types
   localparam logic [3:0] BURST_MPEG1_L1   = 4'd4;
   localparam logic [3:0] BURST_MPEG1_L23  = 4'd5;
   localparam logic [3:0] BURST_LSF_L1     = 4'd8;
   localparam logic [3:0] BURST_LSF_L23    = 4'd9;

   localparam logic [10:0] SAMPLES_L1      = 11'd384;
   localparam logic [10:0] SAMPLES_LSF_L3  = 11'd576;
   localparam logic [10:0] SAMPLES_FULL    = 11'd1152;

   // Frame length base = X * 1000 / rate_mpeg1, X = kbps * slots * (lsf ? 2 : 1).
   // 44.1k: X * 10 / 441, 48k: X / 48, 32k: X / 32.
   localparam logic [8:0]  DIV_44K     = 9'd441;
   localparam logic [8:0]  DIV_48K     = 9'd48;
   localparam logic [8:0]  DIV_32K     = 9'd32;
   localparam logic [8:0]  DIV_NONE    = 9'd1;
   localparam int          RECIP_SHIFT = 28;
   localparam logic [19:0] RECIP_441   = 20'd608697;   // floor(2^28 / 441)
   localparam int          THIRD_SHIFT = 17;
   localparam logic [15:0] RECIP_3     = 16'hAAAB;     // ceil(2^17 / 3)

   localparam logic [8:0] KBPS_TBL [0:1][0:2][0:15] = '{
      '{ '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
           9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
         '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
         '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
           9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0} },
      '{ '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
           9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
         '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
           9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0} }
   };

   typedef struct packed {
      logic       hdr_ok;
      logic       swapped;
      logic       lsf;
      logic [1:0] lidx;
      logic [3:0] bidx;
      logic [1:0] sidx;
      logic       pad;
      logic       mono;
   } dec_fields_type;

   typedef struct packed {
      logic        header_valid;
      logic        word_swapped;
      logic [10:0] frame_bytes;
      logic [10:0] samples_per_frame;
      logic [3:0]  burst_data_type;
      logic [15:0] sample_rate_hz;
      logic        low_sampling_ext;
      logic [1:0]  layer_number;
      logic        single_channel;
   } rsp_fields_type;

   function automatic logic hdr_ok(input logic [7:0] a, input logic [7:0] b,
                                   input logic [7:0] c);
      return (a == SYNC_BYTE) && (b[7:4] == SYNC_NIBBLE) &&
             (b[2:1] != LAYER_CODE_RSVD) && (c[7:4] != BITRATE_BAD) &&
             (c[7:4] != BITRATE_FREE) && (c[3:2] != SRATE_RSVD);
   endfunction

   function automatic logic [8:0] kbps_lookup(input logic lsf, input logic [1:0] lidx,
                                              input logic [3:0] bidx);
      logic [8:0] kbps;
      kbps = 9'd0;
      if (lidx <= LAYER_III) begin
         kbps = KBPS_TBL[lsf][lidx][bidx];
      end
      return kbps;
   endfunction

   // slots per frame, doubled for LSF so one divisor set covers both versions
   function automatic logic [8:0] slot_mult(input logic lsf, input logic [1:0] lidx);
      logic [8:0] m;
      if (lidx == LAYER_I) begin
         m = lsf ? 9'd24 : 9'd12;
      end else if (lidx == LAYER_III && lsf) begin
         m = 9'd144;
      end else begin
         m = lsf ? 9'd288 : 9'd144;
      end
      return m;
   endfunction

   function automatic logic [8:0] rate_divisor(input logic [1:0] sidx);
      logic [8:0] d;
      case (sidx)
         SIDX_44K: d = DIV_44K;
         SIDX_48K: d = DIV_48K;
         SIDX_32K: d = DIV_32K;
         default:  d = DIV_NONE;
      endcase
      return d;
   endfunction

   function automatic logic [15:0] rate_hz_of(input logic lsf, input logic [1:0] sidx);
      logic [15:0] r;
      case (sidx)
         SIDX_44K: r = lsf ? 16'd22050 : 16'd44100;
         SIDX_48K: r = lsf ? 16'd24000 : 16'd48000;
         SIDX_32K: r = lsf ? 16'd16000 : 16'd32000;
         default:  r = 16'd0;
      endcase
      return r;
   endfunction

endpackage

### hdl/mahp_req_if.sv
`timescale 1ns / 1ps

interface mahp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] header_bytes;

   modport source (output valid, output header_bytes, input ready);
   modport sink (input valid, input header_bytes, output ready);
endinterface

### hdl/mahp_rsp_if.sv
`timescale 1ns / 1ps

interface mahp_rsp_if;
   logic        valid;
   logic        ready;
   logic        header_valid;
   logic        word_swapped;
   logic [10:0] frame_bytes;
   logic [10:0] samples_per_frame;
   logic [3:0]  burst_data_type;
   logic [15:0] sample_rate_hz;
   logic        low_sampling_ext;
   logic [1:0]  layer_number;
   logic        single_channel;

   modport source (output valid, output header_valid, output word_swapped,
                   output frame_bytes, output samples_per_frame,
                   output burst_data_type, output sample_rate_hz,
                   output low_sampling_ext, output layer_number,
                   output single_channel, input ready);
   modport sink (input valid, input header_valid, input word_swapped,
                 input frame_bytes, input samples_per_frame,
                 input burst_data_type, input sample_rate_hz,
                 input low_sampling_ext, input layer_number,
                 input single_channel, output ready);
endinterface

### hdl/mahp_decode.sv
`timescale 1ns / 1ps

module mahp_decode (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [31:0]              header_bytes,
   output logic                     out_valid,
   input  logic                     out_ready,
   output mahp_pkg::dec_fields_type out_fields
);

   logic [7:0] b0, b1, b2, b3;
   logic [7:0] h1, h2, h3;
   logic       ok_direct, ok_swap;
   mahp_pkg::dec_fields_type fields_in, fields_ff;
   logic       valid_ff;

   assign b0 = header_bytes[31:24];
   assign b1 = header_bytes[23:16];
   assign b2 = header_bytes[15:8];
   assign b3 = header_bytes[7:0];

   assign ok_direct = mahp_pkg::hdr_ok(b0, b1, b2);
   assign ok_swap   = mahp_pkg::hdr_ok(b1, b0, b3);

   always_comb begin
      // direct byte order wins when both readings pass
      if (ok_direct) begin
         h1 = b1;
         h2 = b2;
         h3 = b3;
      end else begin
         h1 = b0;
         h2 = b3;
         h3 = b2;
      end
      fields_in.hdr_ok  = ok_direct | ok_swap;
      fields_in.swapped = ~ok_direct & ok_swap;
      fields_in.lsf     = ~h1[3];
      fields_in.lidx    = 2'(2'd3 - h1[2:1]);
      fields_in.bidx    = h2[7:4];
      fields_in.sidx    = h2[3:2];
      fields_in.pad     = h2[1];
      fields_in.mono    = (h3[7:6] == mahp_pkg::CHMODE_SINGLE);
   end

   assign in_ready = ~valid_ff | out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         fields_ff <= fields_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_fields = fields_ff;

endmodule

### hdl/mahp_frame_len.sv
`timescale 1ns / 1ps

module mahp_frame_len (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  mahp_pkg::dec_fields_type in_fields,
   output logic                     out_valid,
   input  logic                     out_ready,
   output mahp_pkg::rsp_fields_type out_fields
);

   typedef struct packed {
      mahp_pkg::dec_fields_type f;
      logic [15:0]              x;
   } prod_stage_type;

   typedef struct packed {
      mahp_pkg::dec_fields_type f;
      logic [10:0]              q0;
      logic [19:0]              z;
   } quot_stage_type;

   prod_stage_type s2_in, s2_ff;
   quot_stage_type s3_in, s3_ff;
   logic           v2_ff, v3_ff;
   logic           s2_ready, s3_ready;

   logic [8:0]  kbps;
   logic [17:0] x_full;
   logic [39:0] prod44;
   logic [11:0] y48;
   logic [27:0] prod48;

   logic [8:0]  div;
   logic [19:0] qd, rem;
   logic [11:0] q, base;
   logic [13:0] fb;

   assign s3_ready = ~v3_ff | out_ready;
   assign s2_ready = ~v2_ff | s3_ready;
   assign in_ready = s2_ready;

   // stage 2: bitrate lookup, scale by slots
   always_comb begin
      kbps    = mahp_pkg::kbps_lookup(in_fields.lsf, in_fields.lidx, in_fields.bidx);
      x_full  = 18'(kbps) * 18'(mahp_pkg::slot_mult(in_fields.lsf, in_fields.lidx));
      s2_in.f = in_fields;
      s2_in.x = x_full[15:0];
   end

   // stage 3: quotient estimate by reciprocal multiply
   always_comb begin
      s3_in.f = s2_ff.f;
      if (s2_ff.f.sidx == mahp_pkg::SIDX_44K) begin
         s3_in.z = 20'(s2_ff.x) * 20'd10;
      end else begin
         s3_in.z = 20'(s2_ff.x);
      end
      prod44 = 40'(s3_in.z) * 40'(mahp_pkg::RECIP_441);
      y48    = s2_ff.x[15:4];
      prod48 = 28'(y48) * 28'(mahp_pkg::RECIP_3);
      case (s2_ff.f.sidx)
         mahp_pkg::SIDX_44K: s3_in.q0 = prod44[mahp_pkg::RECIP_SHIFT +: 11];
         mahp_pkg::SIDX_48K: s3_in.q0 = prod48[mahp_pkg::THIRD_SHIFT +: 11];
         mahp_pkg::SIDX_32K: s3_in.q0 = s2_ff.x[15:5];
         default:            s3_in.q0 = 11'd0;
      endcase
   end

   // final: correct the estimate by one, add padding, scale layer I slots
   always_comb begin
      div  = mahp_pkg::rate_divisor(s3_ff.f.sidx);
      qd   = 20'(s3_ff.q0) * 20'(div);
      rem  = s3_ff.z - qd;
      q    = 12'(s3_ff.q0) + ((rem >= 20'(div)) ? 12'd1 : 12'd0);
      base = q + 12'(s3_ff.f.pad);
      if (s3_ff.f.lidx == mahp_pkg::LAYER_I) begin
         fb = {base, 2'b00};
      end else begin
         fb = 14'(base);
      end

      out_fields = '0;
      if (s3_ff.f.hdr_ok) begin
         out_fields.header_valid     = 1'b1;
         out_fields.word_swapped     = s3_ff.f.swapped;
         out_fields.frame_bytes      = fb[10:0];
         out_fields.sample_rate_hz   = mahp_pkg::rate_hz_of(s3_ff.f.lsf, s3_ff.f.sidx);
         out_fields.low_sampling_ext = s3_ff.f.lsf;
         out_fields.layer_number     = 2'(s3_ff.f.lidx + 2'd1);
         out_fields.single_channel   = s3_ff.f.mono;
         if (s3_ff.f.lidx == mahp_pkg::LAYER_I) begin
            out_fields.samples_per_frame = mahp_pkg::SAMPLES_L1;
         end else if (s3_ff.f.lidx == mahp_pkg::LAYER_III && s3_ff.f.lsf) begin
            out_fields.samples_per_frame = mahp_pkg::SAMPLES_LSF_L3;
         end else begin
            out_fields.samples_per_frame = mahp_pkg::SAMPLES_FULL;
         end
         if (s3_ff.f.lsf) begin
            out_fields.burst_data_type = (s3_ff.f.lidx == mahp_pkg::LAYER_I) ?
                                         mahp_pkg::BURST_LSF_L1 : mahp_pkg::BURST_LSF_L23;
         end else begin
            out_fields.burst_data_type = (s3_ff.f.lidx == mahp_pkg::LAYER_I) ?
                                         mahp_pkg::BURST_MPEG1_L1 :
                                         mahp_pkg::BURST_MPEG1_L23;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (s2_ready) begin
            v2_ff <= in_valid;
         end
         if (s3_ready) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready && in_valid) begin
         s2_ff <= s2_in;
      end
      if (s3_ready && v2_ff) begin
         s3_ff <= s3_in;
      end
   end

   assign out_valid = v3_ff;

endmodule

### hdl/mpeg_audio_header_parse_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Beat payload
// req_chan  in   header_bytes: four stream bytes, first in [31:24]
// rsp_chan  out  header_valid .. single_channel: one decoded header per request
//
// One beat per cycle sustained while responses are taken. Each request passes
// through decode/order select, bitrate scale, reciprocal quotient, then
// quotient correction into the output register.
// Reset clears the stage valid bits only.
// Each stage advances whenever the stage ahead of it is empty or draining, so a
// stalled response holds its beat and bubbles behind it close up.

module mpeg_audio_header_parse_core (
   input  logic       clock,
   input  logic       reset,
   mahp_req_if.sink   req_chan,
   mahp_rsp_if.source rsp_chan
);

   mahp_pkg::dec_fields_type dec_fields;
   mahp_pkg::rsp_fields_type len_fields, rsp_ff;
   logic dec_valid, dec_ready;
   logic len_valid, len_ready;
   logic rsp_valid_ff;

   mahp_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_chan.valid),
      .in_ready     (req_chan.ready),
      .header_bytes (req_chan.header_bytes),
      .out_valid    (dec_valid),
      .out_ready    (dec_ready),
      .out_fields   (dec_fields)
   );

   mahp_frame_len u_frame_len (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (dec_valid),
      .in_ready   (dec_ready),
      .in_fields  (dec_fields),
      .out_valid  (len_valid),
      .out_ready  (len_ready),
      .out_fields (len_fields)
   );

   assign len_ready = ~rsp_valid_ff | rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (len_ready) begin
         rsp_valid_ff <= len_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (len_ready && len_valid) begin
         rsp_ff <= len_fields;
      end
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.header_valid      = rsp_ff.header_valid;
   assign rsp_chan.word_swapped      = rsp_ff.word_swapped;
   assign rsp_chan.frame_bytes       = rsp_ff.frame_bytes;
   assign rsp_chan.samples_per_frame = rsp_ff.samples_per_frame;
   assign rsp_chan.burst_data_type   = rsp_ff.burst_data_type;
   assign rsp_chan.sample_rate_hz    = rsp_ff.sample_rate_hz;
   assign rsp_chan.low_sampling_ext  = rsp_ff.low_sampling_ext;
   assign rsp_chan.layer_number      = rsp_ff.layer_number;
   assign rsp_chan.single_channel    = rsp_ff.single_channel;

   // a rejected header carries an all-zero beat
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.header_valid) |->
         (rsp_chan.frame_bytes == 11'd0 && rsp_chan.layer_number == 2'd0 &&
          rsp_chan.sample_rate_hz == 16'd0 && !rsp_chan.word_swapped))
      else $error("rejected header with nonzero fields");

   // an accepted header reports a real layer, rate, frame length and burst type
   a_accept_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.header_valid) |->
         (rsp_chan.layer_number != 2'd0 && rsp_chan.sample_rate_hz != 16'd0 &&
          rsp_chan.frame_bytes != 11'd0 &&
          (rsp_chan.burst_data_type == mahp_pkg::BURST_MPEG1_L1 ||
           rsp_chan.burst_data_type == mahp_pkg::BURST_MPEG1_L23 ||
           rsp_chan.burst_data_type == mahp_pkg::BURST_LSF_L1 ||
           rsp_chan.burst_data_type == mahp_pkg::BURST_LSF_L23)))
      else $error("accepted header with bad fields");

   // burst type family follows the version
   a_burst_lsf: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.header_valid) |->
         (rsp_chan.low_sampling_ext ==
          (rsp_chan.burst_data_type == mahp_pkg::BURST_LSF_L1 ||
           rsp_chan.burst_data_type == mahp_pkg::BURST_LSF_L23)))
      else $error("burst type disagrees with version");

   // no response beat straight out of reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

endmodule
